// ----- hdl/tra_pkg.sv -----
package tra_pkg;

  // fixed field widths
  localparam int NDIM      = 4;
  localparam int DIM_W     = $clog2(NDIM);
  localparam int SIZE_W    = 13;
  localparam int SHIFT_W   = 14;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_W     = 14;
  localparam int DATA_W    = 32;
  localparam int DEST_W    = 48;

  // parameter defaults
  localparam int RANK_DEF      = 4;
  localparam int ELEM_BITS_DEF = 32;
  localparam int SIZE_BITS_DEF = 12;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_0  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_1  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_2  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_3  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_2 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_3 = 4'd7;

  // control from the configuration side to the address walker
  typedef struct packed {
    logic busy;     // setup sequence running, hold off input beats
    logic restart;  // reload counters and partial terms
  } tra_ctrl_t;

  // one result beat
  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic [DATA_W-1:0] value;
    logic              last;
  } tra_beat_t;

endpackage

// ----- hdl/tra_norm_div.sv -----
module tra_norm_div #(
  parameter int SIZE_BITS = tra_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tra_pkg::SHIFT_W-1:0]  shift,
  input  logic [SIZE_BITS:0]           divisor,
  output logic                         done,
  output logic [SIZE_BITS-1:0]         rem
);
  import tra_pkg::*;

  localparam int NW    = SIZE_BITS + 1;
  localparam int CNT_W = $clog2(SHIFT_W + 1);

  logic               run_r;
  logic               fin_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SHIFT_W-1:0] mag_r;
  logic [NW-1:0]      rem_r;
  logic [NW:0]        trial;
  logic [NW:0]        diff;
  logic [NW-1:0]      fixed;

  // one restoring step: bring in the next magnitude bit, subtract if it fits
  assign trial = {rem_r, mag_r[SHIFT_W-1]};
  assign diff  = trial - {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CNT_W'(1)) begin
        run_r <= 1'b0;
        fin_r <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= shift[SHIFT_W-1];
      mag_r <= shift[SHIFT_W-1] ? (~shift + SHIFT_W'(1)) : shift;
      rem_r <= '0;
      cnt_r <= CNT_W'(SHIFT_W);
    end else if (run_r) begin
      mag_r <= mag_r << 1;
      rem_r <= (trial >= {1'b0, divisor}) ? diff[NW-1:0] : trial[NW-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // negative shift counts from the end
  assign fixed = (neg_r && rem_r != '0) ? (divisor - rem_r) : rem_r;
  assign rem   = fixed[SIZE_BITS-1:0];
  assign done  = fin_r;

endmodule

// ----- hdl/tra_cfg.sv -----
module tra_cfg #(
  parameter int RANK      = tra_pkg::RANK_DEF,
  parameter int SIZE_BITS = tra_pkg::SIZE_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             cfg_valid,
  output logic                                             cfg_ready,
  input  logic [tra_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [tra_pkg::CFG_W-1:0]                        cfg_data,
  output tra_pkg::tra_ctrl_t                               ctrl,
  output logic [tra_pkg::NDIM-1:0][SIZE_BITS-1:0]          lim,
  output logic [tra_pkg::NDIM-1:0][SIZE_BITS-1:0]          norm,
  output logic [tra_pkg::NDIM-1:0][tra_pkg::DEST_W-1:0]    stride,
  output logic [tra_pkg::NDIM-1:0][tra_pkg::DEST_W-1:0]    pinit
);
  import tra_pkg::*;

  localparam int NW = SIZE_BITS + 1;
  localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;
  localparam logic [CW-1:0] CAP = CW'(1) << SIZE_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DIV, S_ST1, S_ST0, S_P2, S_P1, S_P0, S_RESTART
  } state_t;

  state_t                           state_r;
  logic [DIM_W-1:0]                 dim_r;
  logic [NDIM-1:0][SIZE_W-1:0]      size_r;
  logic [NDIM-1:0][SHIFT_W-1:0]     shift_r;
  logic [NDIM-1:0][SIZE_BITS-1:0]   norm_r;
  logic [DEST_W-1:0]                stride0_r;
  logic [DEST_W-1:0]                stride1_r;
  logic [DEST_W-1:0]                stride2_r;
  logic [NDIM-2:0][DEST_W-1:0]      pinit_r;
  logic [NDIM-1:0][NW-1:0]          eff;
  logic [NDIM-1:0][CW-1:0]          effw;
  logic                             wr;
  logic                             div_start;
  logic                             div_done;
  logic [SIZE_BITS-1:0]             div_rem;
  logic [NW-1:0]                    mul_a;
  logic [DEST_W-1:0]                mul_b;
  logic [DEST_W-1:0]                prod;

  // effective sizes: zero reads as one, saturate at the cap, unused dims are one
  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      if (d >= RANK || size_r[d] == '0) begin
        effw[d] = CW'(1);
      end else if (CW'(size_r[d]) > CAP) begin
        effw[d] = CAP;
      end else begin
        effw[d] = CW'(size_r[d]);
      end
      eff[d] = effw[d][NW-1:0];
      lim[d] = SIZE_BITS'(eff[d] - NW'(1));
    end
  end

  assign wr        = cfg_valid && cfg_ready;
  assign cfg_ready = (state_r == S_IDLE);
  assign div_start = (state_r == S_START);

  tra_norm_div #(
    .SIZE_BITS(SIZE_BITS)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .shift  (shift_r[dim_r]),
    .divisor(eff[dim_r]),
    .done   (div_done),
    .rem    (div_rem)
  );

  // shared multiplier for strides and starting partial terms
  always_comb begin
    mul_a = eff[1];
    mul_b = stride1_r;
    case (state_r)
      S_ST1: begin
        mul_a = eff[2];
        mul_b = DEST_W'(eff[3]);
      end
      S_P2: begin
        mul_a = NW'(norm_r[2]);
        mul_b = stride2_r;
      end
      S_P1: begin
        mul_a = NW'(norm_r[1]);
        mul_b = stride1_r;
      end
      S_P0: begin
        mul_a = NW'(norm_r[0]);
        mul_b = stride0_r;
      end
      default: ;
    endcase
  end

  assign prod = mul_b * DEST_W'(mul_a);

  // registers and setup sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dim_r     <= '0;
      for (int d = 0; d < NDIM; d++) begin
        size_r[d]  <= SIZE_W'(1);
        shift_r[d] <= '0;
        norm_r[d]  <= '0;
      end
      stride0_r <= DEST_W'(1);
      stride1_r <= DEST_W'(1);
      stride2_r <= DEST_W'(1);
      pinit_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (wr) begin
            dim_r <= cfg_index[DIM_W-1:0];
            unique case (cfg_index) inside
              REG_SIZE_0, REG_SIZE_1, REG_SIZE_2, REG_SIZE_3: begin
                size_r[cfg_index[DIM_W-1:0]] <= cfg_data[SIZE_W-1:0];
                state_r <= S_START;
              end
              REG_SHIFT_0, REG_SHIFT_1, REG_SHIFT_2, REG_SHIFT_3: begin
                shift_r[cfg_index[DIM_W-1:0]] <= cfg_data[SHIFT_W-1:0];
                state_r <= S_START;
              end
              default: ;
            endcase
          end
        end
        S_START: state_r <= S_DIV;
        S_DIV: begin
          if (div_done) begin
            norm_r[dim_r] <= div_rem;
            state_r       <= S_ST1;
          end
        end
        S_ST1: begin
          stride2_r <= DEST_W'(eff[3]);
          stride1_r <= prod;
          state_r   <= S_ST0;
        end
        S_ST0: begin
          stride0_r <= prod;
          state_r   <= S_P2;
        end
        S_P2: begin
          pinit_r[2] <= prod;
          state_r    <= S_P1;
        end
        S_P1: begin
          pinit_r[1] <= prod;
          state_r    <= S_P0;
        end
        S_P0: begin
          pinit_r[0] <= prod;
          state_r    <= S_RESTART;
        end
        S_RESTART: state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end

  assign ctrl.busy    = (state_r != S_IDLE);
  assign ctrl.restart = (state_r == S_RESTART);

  assign norm      = norm_r;
  assign stride[0] = stride0_r;
  assign stride[1] = stride1_r;
  assign stride[2] = stride2_r;
  assign stride[3] = DEST_W'(1);
  assign pinit[0]  = pinit_r[0];
  assign pinit[1]  = pinit_r[1];
  assign pinit[2]  = pinit_r[2];
  assign pinit[3]  = DEST_W'(norm_r[3]);

endmodule

// ----- hdl/tra_walk.sv -----
module tra_walk #(
  parameter int ELEM_BITS = tra_pkg::ELEM_BITS_DEF,
  parameter int SIZE_BITS = tra_pkg::SIZE_BITS_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  tra_pkg::tra_ctrl_t                               ctrl,
  input  logic [tra_pkg::NDIM-1:0][SIZE_BITS-1:0]          lim,
  input  logic [tra_pkg::NDIM-1:0][SIZE_BITS-1:0]          norm,
  input  logic [tra_pkg::NDIM-1:0][tra_pkg::DEST_W-1:0]    stride,
  input  logic [tra_pkg::NDIM-1:0][tra_pkg::DEST_W-1:0]    pinit,
  input  logic                                             in_valid,
  output logic                                             in_stall,
  input  logic [tra_pkg::DATA_W-1:0]                       in_elem_value,
  output logic                                             out_valid,
  input  logic                                             out_stall,
  output logic [tra_pkg::DEST_W-1:0]                       out_dest_index,
  output logic [tra_pkg::DATA_W-1:0]                       out_value,
  output logic                                             out_tensor_end
);
  import tra_pkg::*;

  localparam logic [DATA_W-1:0] ELEM_MASK =
    (ELEM_BITS >= DATA_W) ? '1 : ((DATA_W'(1) << ELEM_BITS) - DATA_W'(1));

  logic [NDIM-1:0][SIZE_BITS-1:0] coord_r;
  logic [NDIM-1:0][SIZE_BITS-1:0] rolled_r;
  logic [NDIM-1:0][DEST_W-1:0]    part_r;
  logic [NDIM-1:0]                inc;
  logic                           last;
  logic                           accept;
  logic                           take;
  logic                           out_v_r;
  logic                           skid_v_r;
  tra_beat_t                      out_r;
  tra_beat_t                      skid_r;
  tra_beat_t                      beat;

  assign in_stall = ctrl.busy || skid_v_r;
  assign accept   = in_valid && !in_stall;
  assign take     = out_v_r && !out_stall;

  // carry chain from the innermost dimension
  always_comb begin
    inc[NDIM-1] = 1'b1;
    for (int d = NDIM - 1; d > 0; d--) begin
      inc[d-1] = inc[d] && (coord_r[d] == lim[d]);
    end
    last = inc[0] && (coord_r[0] == lim[0]);
  end

  // destination index is the sum of the per-dimension terms
  assign beat.dest  = part_r[0] + part_r[1] + part_r[2] + part_r[3];
  assign beat.value = in_elem_value & ELEM_MASK;
  assign beat.last  = last;

  // input and rolled counters, with rolled coord times stride kept per dim
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_r  <= '0;
      rolled_r <= '0;
      part_r   <= '0;
    end else if (ctrl.restart) begin
      coord_r  <= '0;
      rolled_r <= norm;
      part_r   <= pinit;
    end else if (accept) begin
      for (int d = 0; d < NDIM; d++) begin
        if (inc[d]) begin
          coord_r[d] <= (coord_r[d] == lim[d]) ? '0 : coord_r[d] + SIZE_BITS'(1);
          if (rolled_r[d] == lim[d]) begin
            rolled_r[d] <= '0;
            part_r[d]   <= '0;
          end else begin
            rolled_r[d] <= rolled_r[d] + SIZE_BITS'(1);
            part_r[d]   <= part_r[d] + stride[d];
          end
        end
      end
    end
  end

  // output register with skid stage behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= beat;
      end
    end else if (accept) begin
      skid_r <= beat;
    end
  end

  assign out_valid      = out_v_r;
  assign out_dest_index = out_r.dest;
  assign out_value      = out_r.value;
  assign out_tensor_end = out_r.last;

endmodule

// ----- hdl/tensor_roll_address_gen_core.sv -----
// Channel   Handshake            Payload
// cfg       cfg_valid/cfg_ready  cfg_index (register number), cfg_data
// in        in_valid/in_stall    in_elem_value
// out       out_valid/out_stall  out_dest_index, out_value, out_tensor_end
//
// One element per cycle when not stalled: each beat's destination comes from
// per-dimension terms kept up to date by adds, so the output register takes a
// beat every clock. Each size or shift write runs a setup pass (14-step
// remainder unit for the shift, then five steps of one shared multiplier for
// strides and start terms); input is stalled and cfg_ready is low until it ends.
// Synchronous active-low reset leaves sizes 1, shifts 0 and the counters at zero.
// A skid stage behind the output register lets one more beat in under out_stall.
module tensor_roll_address_gen_core #(
  parameter int RANK      = tra_pkg::RANK_DEF,
  parameter int ELEM_BITS = tra_pkg::ELEM_BITS_DEF,
  parameter int SIZE_BITS = tra_pkg::SIZE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tra_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tra_pkg::DATA_W-1:0]     in_elem_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tra_pkg::DEST_W-1:0]     out_dest_index,
  output logic [tra_pkg::DATA_W-1:0]     out_value,
  output logic                           out_tensor_end
);
  import tra_pkg::*;

  tra_ctrl_t                      ctrl;
  logic [NDIM-1:0][SIZE_BITS-1:0] lim;
  logic [NDIM-1:0][SIZE_BITS-1:0] norm;
  logic [NDIM-1:0][DEST_W-1:0]    stride;
  logic [NDIM-1:0][DEST_W-1:0]    pinit;

  // register file and setup sequencer
  tra_cfg #(
    .RANK     (RANK),
    .SIZE_BITS(SIZE_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .ctrl     (ctrl),
    .lim      (lim),
    .norm     (norm),
    .stride   (stride),
    .pinit    (pinit)
  );

  // coordinate walk and output stage
  tra_walk #(
    .ELEM_BITS(ELEM_BITS),
    .SIZE_BITS(SIZE_BITS)
  ) u_walk (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .lim           (lim),
    .norm          (norm),
    .stride        (stride),
    .pinit         (pinit),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_elem_value (in_elem_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dest_index(out_dest_index),
    .out_value     (out_value),
    .out_tensor_end(out_tensor_end)
  );

endmodule

// ----- tb/sv/tra_roll_checker.sv -----
`timescale 1ns / 100ps

// Watches the cfg, in and out channels of the roll address generator, keeps
// its own copy of the shape and the coordinate walk, and compares every
// result beat against the oldest predicted one.
module tra_roll_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tra_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [tra_pkg::DATA_W-1:0]    in_elem_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [tra_pkg::DEST_W-1:0]    out_dest_index,
  input  logic [tra_pkg::DATA_W-1:0]    out_value,
  input  logic                          out_tensor_end,
  output int                            fail_count,
  output int                            open_count
);

  localparam int          ROLL_RANK  = tra_pkg::RANK_DEF;
  localparam int unsigned EXTENT_CAP = 1 << tra_pkg::SIZE_BITS_DEF;

  // shape registers as last written
  logic        [tra_pkg::SIZE_W-1:0]  extent_q [tra_pkg::NDIM];
  logic signed [tra_pkg::SHIFT_W-1:0] roll_q   [tra_pkg::NDIM];

  // source coordinates and their rolled counterparts
  int unsigned src_pos [tra_pkg::NDIM];
  int unsigned dst_pos [tra_pkg::NDIM];

  tra_pkg::tra_beat_t dest_fifo [$];

  int fails    = 0;
  int in_queue = 0;

  assign fail_count = fails;
  assign open_count = in_queue;

  // zero extent counts as 1, oversize saturates
  function automatic int unsigned eff_extent(int d);
    int unsigned n;
    if (d >= ROLL_RANK) return 1;
    n = 32'(extent_q[d]);
    if (n == 0) n = 1;
    if (n > EXTENT_CAP) n = EXTENT_CAP;
    return n;
  endfunction

  // shift brought into [0, extent)
  function automatic int unsigned norm_roll(int d);
    int n;
    int r;
    if (d >= ROLL_RANK) return 0;
    n = int'(eff_extent(d));
    r = int'(roll_q[d]);
    r = r % n;
    if (r < 0) r += n;
    return r;
  endfunction

  function automatic void restart_walk();
    for (int d = 0; d < tra_pkg::NDIM; d++) begin
      src_pos[d] = 0;
      dst_pos[d] = norm_roll(d);
    end
  endfunction

  function automatic void apply_write(logic [tra_pkg::CFG_IDX_W-1:0] idx,
                                      logic [tra_pkg::CFG_W-1:0] data);
    if (idx <= tra_pkg::REG_SIZE_3)
      extent_q[idx[tra_pkg::DIM_W-1:0]] = data[tra_pkg::SIZE_W-1:0];
    else if (idx <= tra_pkg::REG_SHIFT_3) roll_q[idx[tra_pkg::DIM_W-1:0]] = data;
    else return;  // unused index: no effect, walk keeps going
    restart_walk();
  endfunction

  // destination of the current element, then advance both walks
  function automatic tra_pkg::tra_beat_t roll_next(logic [tra_pkg::DATA_W-1:0] v);
    tra_pkg::tra_beat_t beat;
    int unsigned        n [tra_pkg::NDIM];
    longint unsigned    acc;
    logic               at_end;
    acc    = 0;
    at_end = 1'b1;
    for (int d = 0; d < tra_pkg::NDIM; d++) begin
      n[d] = eff_extent(d);
      acc  = acc * n[d] + dst_pos[d];
      if (src_pos[d] != n[d] - 1) at_end = 1'b0;
    end
    beat.dest  = acc[tra_pkg::DEST_W-1:0];
    beat.value = v;
    beat.last  = at_end;
    for (int d = tra_pkg::NDIM - 1; d >= 0; d--) begin
      src_pos[d]++;
      dst_pos[d]++;
      if (dst_pos[d] >= n[d]) dst_pos[d] = 0;
      if (src_pos[d] < n[d]) break;
      src_pos[d] = 0;
    end
    return beat;
  endfunction

  always @(posedge clk) begin
    tra_pkg::tra_beat_t want;
    if (!rst_n) begin
      for (int d = 0; d < tra_pkg::NDIM; d++) begin
        extent_q[d] = tra_pkg::SIZE_W'(1);
        roll_q[d]   = '0;
      end
      restart_walk();
      dest_fifo.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);

      // result beat against oldest prediction
      if (out_valid && !out_stall) begin
        if (dest_fifo.size() == 0) begin
          $error("result beat with nothing expected: dest_index %0h", out_dest_index);
          fails++;
        end else begin
          want = dest_fifo.pop_front();
          if (out_dest_index !== want.dest) begin
            $error("dest_index mismatch: expected %0h, got %0h", want.dest, out_dest_index);
            fails++;
          end
          if (out_value !== want.value) begin
            $error("out_value mismatch: expected %0h, got %0h", want.value, out_value);
            fails++;
          end
          if (out_tensor_end !== want.last) begin
            $error("tensor_end mismatch: expected %0b, got %0b", want.last, out_tensor_end);
            fails++;
          end
        end
      end

      if (in_valid && !in_stall) dest_fifo.push_back(roll_next(in_elem_value));
    end
    in_queue <= dest_fifo.size();
  end

endmodule

// ----- tb/sv/tb_tensor_roll_address_gen_core.sv -----
`timescale 1ns / 100ps

module tb_tensor_roll_address_gen_core;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic                          clk;
  logic                          rst_n         = 1'b0;
  logic                          cfg_valid     = 1'b0;
  logic                          cfg_ready;
  logic [tra_pkg::CFG_IDX_W-1:0] cfg_index     = '0;
  logic [tra_pkg::CFG_W-1:0]     cfg_data      = '0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic [tra_pkg::DATA_W-1:0]    in_elem_value = '0;
  logic                          out_valid;
  logic                          out_stall     = 1'b1;
  logic [tra_pkg::DEST_W-1:0]    out_dest_index;
  logic [tra_pkg::DATA_W-1:0]    out_value;
  logic                          out_tensor_end;

  int   fail_count;
  int   open_count;
  int   send_idle_pct = 25;
  int   recv_idle_pct = 70;
  logic long_hold     = 1'b0;
  int   hold_cnt      = 0;
  int   cycle_cnt     = 0;

  tensor_roll_address_gen_core i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_elem_value  (in_elem_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dest_index (out_dest_index),
    .out_value      (out_value),
    .out_tensor_end (out_tensor_end)
  );

  tra_roll_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_elem_value  (in_elem_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dest_index (out_dest_index),
    .out_value      (out_value),
    .out_tensor_end (out_tensor_end),
    .fail_count     (fail_count),
    .open_count     (open_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stall, or a long hold-off while long_hold is up
  always @(posedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!long_hold) hold_cnt <= 0;
    end
  end

  // one element beat, then a random gap
  task automatic push_elem(logic [tra_pkg::DATA_W-1:0] v);
    int gap;
    in_valid      <= 1'b1;
    in_elem_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every predicted beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; caller drops it after the last write
  task automatic write_reg(logic [tra_pkg::CFG_IDX_W-1:0] idx, logic [tra_pkg::CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // mostly tiny extents so tensors end often; sometimes zero or oversize
  function automatic logic [tra_pkg::SIZE_W-1:0] rand_extent();
    int pick;
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 5) return tra_pkg::SIZE_W'($urandom_range(4096, 8191));
    return tra_pkg::SIZE_W'($urandom_range(1, 4));
  endfunction

  task automatic run_mode(int send_pct, int recv_pct, int n_items);
    int sent;
    int burst;
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    sent = 0;
    while (sent < n_items) begin
      wait_drained();
      // new shape: each register rewritten at even odds
      for (int r = 0; r < tra_pkg::NDIM; r++) begin
        if ($urandom_range(1))
          write_reg(tra_pkg::CFG_IDX_W'(tra_pkg::REG_SIZE_0 + r),
                    {1'($urandom_range(1)), rand_extent()});
        if ($urandom_range(1))
          write_reg(tra_pkg::CFG_IDX_W'(tra_pkg::REG_SHIFT_0 + r), tra_pkg::CFG_W'($urandom));
      end
      if ($urandom_range(9) == 0)
        write_reg(tra_pkg::CFG_IDX_W'(tra_pkg::REG_SHIFT_3 + 1 + $urandom_range(7)),
                  tra_pkg::CFG_W'($urandom));
      cfg_valid <= 1'b0;

      // first batch of each mode runs under a long receiver hold-off
      burst = $urandom_range(5, 40);
      if (sent == 0) begin
        long_hold <= 1'b1;
        burst = 60;
      end
      for (int i = 0; i < burst; i++) begin
        push_elem($urandom);
        if ($urandom_range(49) == 0) wait_drained();
      end
      long_hold <= 1'b0;
      sent += burst;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset shape: each element is a whole tensor at index 0
    push_elem(32'h0000_0000);
    push_elem(32'hFFFF_FFFF);
    push_elem(32'hAAAA_AAAA);
    push_elem(32'h5555_5555);
    wait_drained();

    // full extents rolled by -1: first destination is the top index
    for (int d = 0; d < tra_pkg::NDIM; d++)
      write_reg(tra_pkg::CFG_IDX_W'(tra_pkg::REG_SIZE_0 + d), 14'd4096);
    for (int d = 0; d < tra_pkg::NDIM; d++)
      write_reg(tra_pkg::CFG_IDX_W'(tra_pkg::REG_SHIFT_0 + d), 14'h3FFF);
    cfg_valid <= 1'b0;
    repeat (3) push_elem($urandom);
    wait_drained();

    // zero extent, saturated extent, dropped top bit, shift extremes
    write_reg(tra_pkg::REG_SIZE_0, 14'd0);
    write_reg(tra_pkg::REG_SIZE_1, 14'd8191);
    write_reg(tra_pkg::REG_SIZE_2, 14'd3);
    write_reg(tra_pkg::REG_SIZE_3, 14'h2005);
    write_reg(tra_pkg::REG_SHIFT_0, 14'h2000);
    write_reg(tra_pkg::REG_SHIFT_1, 14'h1FFF);
    write_reg(tra_pkg::REG_SHIFT_2, 14'd4096);
    write_reg(tra_pkg::REG_SHIFT_3, 14'h3000);
    cfg_valid <= 1'b0;
    repeat (6) push_elem($urandom);
    wait_drained();

    // 2x1x1x3 tensor; unused-index writes mid-tensor must not restart it
    write_reg(tra_pkg::REG_SIZE_0, 14'd2);
    write_reg(tra_pkg::REG_SIZE_1, 14'd1);
    write_reg(tra_pkg::REG_SIZE_2, 14'd1);
    write_reg(tra_pkg::REG_SIZE_3, 14'd3);
    write_reg(tra_pkg::REG_SHIFT_0, 14'd1);
    write_reg(tra_pkg::REG_SHIFT_1, 14'd0);
    write_reg(tra_pkg::REG_SHIFT_2, 14'd0);
    write_reg(tra_pkg::REG_SHIFT_3, 14'h3FFE);
    cfg_valid <= 1'b0;
    repeat (3) push_elem($urandom);
    wait_drained();
    write_reg(tra_pkg::CFG_IDX_W'(tra_pkg::REG_SHIFT_3 + 2), 14'h3FFF);
    write_reg(tra_pkg::CFG_IDX_W'(tra_pkg::REG_SHIFT_3 + 8), 14'h0000);
    cfg_valid <= 1'b0;
    repeat (5) push_elem($urandom);

    // random shapes under three idle mixes
    run_mode(25, 70, 500);
    run_mode(70, 25, 500);
    run_mode(0, 0, 500);

    wait_drained();
    repeat (30) @(posedge clk);
    if (fail_count == 0 && open_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
